/* rtl/quadrature_step_pulse_generator_defines.svh */
// Assertion macros for the quadrature / step-direction pulse generator.
// The macros expect clk and rst_n in scope where they are used.
`ifndef QUADRATURE_STEP_PULSE_GENERATOR_DEFINES_SVH
`define QUADRATURE_STEP_PULSE_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS

`define QSPG_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`define QSPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define QSPG_ASSERT(label, expr, msg)

`define QSPG_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* rtl/qspg_pkg.sv */
`default_nettype none

package qspg_pkg;

    localparam int MOVE_W     = 16;
    localparam int MAG_W      = 16;
    localparam int SPAN_W     = 32;
    localparam int POS_W      = 32;
    localparam int STEPS_W    = 16;
    localparam int DIV_STEPS  = 32;
    localparam int DIV_CNT_W  = 5;

    // Gray state bits, state encoded as {A, B}
    localparam logic [1:0] STATE_B = 2'h1;
    localparam logic [1:0] STATE_A = 2'h2;

    typedef enum logic [1:0] {
        REG_QUAD_MODE     = 2'd0,
        REG_COUNT_DISABLE = 2'd1,
        REG_MOVE_SPAN     = 2'd2
    } qspg_reg_idx_t;

    typedef struct packed {
        logic tick_go;
        logic div_start;
        logic div_step;
        logic move_load;
        logic out_load;
    } qspg_ctrl_t;

    typedef struct packed {
        logic move_nz;
        logic div_last;
    } qspg_status_t;

    // Next A/B state: 00,10,11,01 going positive, reverse going negative
    function automatic logic [1:0] qspg_gray_next(input logic [1:0] cur, input logic neg);
        logic [1:0] nxt;
        begin
            nxt = cur;
            if (!neg)
            begin
                case (cur)
                    2'b00:   nxt = STATE_A;
                    2'b01:   nxt = 2'b00;
                    2'b10:   nxt = STATE_A | STATE_B;
                    2'b11:   nxt = STATE_B;
                    default: nxt = 2'b00;
                endcase
            end
            else
            begin
                case (cur)
                    2'b00:   nxt = STATE_B;
                    2'b01:   nxt = STATE_A | STATE_B;
                    2'b10:   nxt = 2'b00;
                    2'b11:   nxt = STATE_A;
                    default: nxt = 2'b00;
                endcase
            end
            return nxt;
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/quadrature_step_pulse_generator.sv */
// One motion output channel: quadrature A/B or step/direction pulses.
// Input channel (in_valid/in_ready) carries cmd and move_count: cmd 0 is a
// timer tick, cmd 1 starts a move of move_count signed steps. Every accepted
// item yields one result on the output channel (out_valid/out_ready): pin
// levels, step_strobe, busy_res, steps_left and position after the item.
// Ticks and zero-count moves: result valid in the cycle after acceptance, one
// item per cycle while out_ready stays high.
// Nonzero moves: the step period comes from a bit-serial restoring divider
// that retires one quotient bit per cycle, and in_ready stays low until the
// result appears.
// Registers are written through cfg_we/cfg_index/cfg_data: index 0 quad_mode,
// 1 count_disable, 2 move_span; write them only while no item is in flight.
// Reset clears the channel: step/direction mode with pin_a high and pin_b low,
// position zero, no move running, move_span 1000000.
// While a result waits with out_ready low, in_ready stays low and the channel
// state holds.
`default_nettype none

`include "quadrature_step_pulse_generator_defines.svh"

module quadrature_step_pulse_generator #(
    parameter int PERIOD_WIDTH = 16,
    parameter int COUNT_WIDTH  = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  cmd,
    input  wire logic signed [qspg_pkg::MOVE_W-1:0]    move_count,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic                                       pin_a,
    output logic                                       pin_b,
    output logic                                       step_strobe,
    output logic                                       busy_res,
    output logic [qspg_pkg::STEPS_W-1:0]               steps_left,
    output logic signed [qspg_pkg::POS_W-1:0]          position,
    input  wire logic                                  cfg_we,
    input  wire logic [1:0]                            cfg_index,
    input  wire logic [qspg_pkg::SPAN_W-1:0]           cfg_data
);
    import qspg_pkg::*;

    qspg_ctrl_t   ctl;
    qspg_status_t st;

    qspg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cmd       (cmd),
        .out_ready (out_ready),
        .st        (st),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .ctl       (ctl)
    );

    qspg_datapath #(
        .PERIOD_WIDTH (PERIOD_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .st          (st),
        .move_count  (move_count),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pin_a       (pin_a),
        .pin_b       (pin_b),
        .step_strobe (step_strobe),
        .busy_res    (busy_res),
        .steps_left  (steps_left),
        .position    (position)
    );

    `QSPG_ASSERT(a_no_accept_over_result, !(in_valid && in_ready) || !out_valid || out_ready, "item accepted while result unread")
    `QSPG_ASSERT(a_busy_matches_count, busy_res == (steps_left != '0), "busy flag disagrees with remaining steps")
    `QSPG_ASSERT_NEXT(a_move_blocks_input, in_valid && in_ready && cmd && (move_count != '0), !in_ready, "input not held during division")
    `QSPG_ASSERT(a_single_load, !(ctl.tick_go && ctl.move_load), "tick and move commit in one cycle")

endmodule

`default_nettype wire

/* rtl/qspg_ctrl.sv */
`default_nettype none

module qspg_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  cmd,
    input  wire logic                  out_ready,
    input  wire qspg_pkg::qspg_status_t st,
    output logic                       in_ready,
    output logic                       out_valid,
    output qspg_pkg::qspg_ctrl_t       ctl
);
    import qspg_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   go_div;

    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
        accept        = in_valid && in_ready;
        go_div        = accept && cmd && st.move_nz;

        ctl.tick_go   = accept && !cmd;
        ctl.div_start = go_div;
        ctl.div_step  = (state_reg == ST_DIV);
        ctl.move_load = (state_reg == ST_DIV) && st.div_last;
        ctl.out_load  = (accept && !go_div) || ctl.move_load;

        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (go_div)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (st.div_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // hold the result until taken
        out_valid_next = out_valid_reg;
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* rtl/qspg_datapath.sv */
`default_nettype none

module qspg_datapath #(
    parameter int PERIOD_WIDTH = 16,
    parameter int COUNT_WIDTH  = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire qspg_pkg::qspg_ctrl_t                  ctl,
    output qspg_pkg::qspg_status_t                     st,
    input  wire logic signed [qspg_pkg::MOVE_W-1:0]    move_count,
    input  wire logic                                  cfg_we,
    input  wire logic [1:0]                            cfg_index,
    input  wire logic [qspg_pkg::SPAN_W-1:0]           cfg_data,
    output logic                                       pin_a,
    output logic                                       pin_b,
    output logic                                       step_strobe,
    output logic                                       busy_res,
    output logic [qspg_pkg::STEPS_W-1:0]               steps_left,
    output logic signed [qspg_pkg::POS_W-1:0]          position
);
    import qspg_pkg::*;

    localparam logic [32:0] CMASK = (33'd1 << COUNT_WIDTH) - 33'd1;
    localparam logic [32:0] PMASK = (33'd1 << PERIOD_WIDTH) - 33'd1;

    // configuration
    logic                     quad_mode_reg;
    logic                     count_disable_reg;
    logic [SPAN_W-1:0]        move_span_reg;

    // channel state
    logic                     a_reg,         a_next;
    logic                     b_reg,         b_next;
    logic                     dir_reg,       dir_next;
    logic [COUNT_WIDTH-1:0]   remaining_reg, remaining_next;
    logic [PERIOD_WIDTH-1:0]  period_reg,    period_next;
    logic [PERIOD_WIDTH-1:0]  interval_reg,  interval_next;
    logic [POS_W-1:0]         position_reg,  position_next;
    logic                     running_reg,   running_next;
    logic                     strobe_reg,    strobe_next;

    // divider
    logic                     neg_reg;
    logic [COUNT_WIDTH-1:0]   mag_reg;
    logic [MAG_W-1:0]         rem_reg;
    logic [SPAN_W-1:0]        quo_reg;
    logic [DIV_CNT_W-1:0]     div_cnt_reg;

    logic [MOVE_W-1:0]        raw;
    logic [MAG_W:0]           mag_abs;
    logic [32:0]              mag_ext;
    logic [32:0]              mag_sat_ext;
    logic [32:0]              div_ext;
    logic [MAG_W-1:0]         divisor;
    logic [MAG_W:0]           trial;
    logic [MAG_W:0]           diff;
    logic                     fits;
    logic [MAG_W-1:0]         rem_step;
    logic [SPAN_W-1:0]        quo_step;
    logic [32:0]              q_ext;
    logic [PERIOD_WIDTH-1:0]  period_load;
    logic [COUNT_WIDTH-1:0]   remaining_dec;
    logic [1:0]               gray;
    logic [32:0]              remaining_ext;

    // magnitude of the move, saturated to the count range
    always_comb
    begin
        raw         = move_count;
        mag_abs     = raw[MOVE_W-1] ? ((MAG_W+1)'(17'h10000) - {1'b0, raw}) : {1'b0, raw};
        mag_ext     = {{(33-MAG_W-1){1'b0}}, mag_abs};
        mag_sat_ext = (mag_ext > CMASK) ? CMASK : mag_ext;
    end

    // one quotient bit per cycle
    always_comb
    begin
        div_ext     = 33'(mag_reg);
        divisor     = div_ext[MAG_W-1:0];
        trial       = {rem_reg, quo_reg[SPAN_W-1]};
        fits        = (trial >= {1'b0, divisor});
        diff        = trial - {1'b0, divisor};
        rem_step    = fits ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
        quo_step    = {quo_reg[SPAN_W-2:0], fits};
        q_ext       = {1'b0, quo_step};
        period_load = (q_ext > PMASK) ? PMASK[PERIOD_WIDTH-1:0] : quo_step[PERIOD_WIDTH-1:0];
        st.move_nz  = (raw != '0);
        st.div_last = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    end

    assign remaining_dec = remaining_reg - COUNT_WIDTH'(1);
    assign gray          = qspg_gray_next({a_reg, b_reg}, dir_reg);

    always_comb
    begin
        a_next         = a_reg;
        b_next         = b_reg;
        dir_next       = dir_reg;
        remaining_next = remaining_reg;
        period_next    = period_reg;
        interval_next  = interval_reg;
        position_next  = position_reg;
        running_next   = running_reg;
        strobe_next    = strobe_reg;

        if (ctl.tick_go)
        begin
            strobe_next = 1'b0;
            if (count_disable_reg)
            begin
                remaining_next = '0;
                interval_next  = '0;
                running_next   = 1'b0;
            end
            else if (running_reg)
            begin
                if (interval_reg >= period_reg)
                begin
                    interval_next = '0;
                    strobe_next   = 1'b1;
                    if (quad_mode_reg)
                    begin
                        a_next = |(gray & STATE_A);
                        b_next = |(gray & STATE_B);
                    end
                    else
                    begin
                        a_next = 1'b1;
                        b_next = dir_reg;
                    end
                    position_next  = dir_reg ? (position_reg - POS_W'(1))
                                             : (position_reg + POS_W'(1));
                    remaining_next = remaining_dec;
                    running_next   = (remaining_dec != '0);
                end
                else
                begin
                    interval_next = interval_reg + PERIOD_WIDTH'(1);
                end
            end
        end
        else if (ctl.move_load)
        begin
            dir_next       = neg_reg;
            remaining_next = mag_reg;
            period_next    = period_load;
            interval_next  = '0;
            running_next   = 1'b1;
            strobe_next    = 1'b0;
        end
        else if (ctl.out_load)
        begin
            // zero-count move: only the strobe is cleared
            strobe_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quad_mode_reg     <= 1'b0;
            count_disable_reg <= 1'b0;
            move_span_reg     <= SPAN_W'(1000000);
            a_reg             <= 1'b0;
            b_reg             <= 1'b0;
            dir_reg           <= 1'b0;
            remaining_reg     <= '0;
            period_reg        <= '0;
            interval_reg      <= '0;
            position_reg      <= '0;
            running_reg       <= 1'b0;
            strobe_reg        <= 1'b0;
            div_cnt_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_QUAD_MODE:     quad_mode_reg     <= cfg_data[0];
                    REG_COUNT_DISABLE: count_disable_reg <= cfg_data[0];
                    REG_MOVE_SPAN:     move_span_reg     <= cfg_data;
                    default:           ;
                endcase
            end
            a_reg         <= a_next;
            b_reg         <= b_next;
            dir_reg       <= dir_next;
            remaining_reg <= remaining_next;
            period_reg    <= period_next;
            interval_reg  <= interval_next;
            position_reg  <= position_next;
            running_reg   <= running_next;
            strobe_reg    <= strobe_next;
            if (ctl.div_start)
            begin
                div_cnt_reg <= '0;
            end
            else if (ctl.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.div_start)
        begin
            neg_reg <= raw[MOVE_W-1];
            mag_reg <= mag_sat_ext[COUNT_WIDTH-1:0];
            rem_reg <= '0;
            quo_reg <= move_span_reg;
        end
        else if (ctl.div_step)
        begin
            rem_reg <= rem_step;
            quo_reg <= quo_step;
        end
    end

    assign remaining_ext = 33'(remaining_reg);

    assign pin_a       = quad_mode_reg ? a_reg : 1'b1;
    assign pin_b       = b_reg;
    assign step_strobe = strobe_reg;
    assign busy_res    = running_reg;
    assign steps_left  = remaining_ext[STEPS_W-1:0];
    assign position    = position_reg;

endmodule

`default_nettype wire

/* bench/qspg_channel_checker.sv */
module qspg_channel_checker
    import qspg_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       cmd,
    input  logic signed [MOVE_W-1:0]   move_count,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic                       pin_a,
    input  logic                       pin_b,
    input  logic                       step_strobe,
    input  logic                       busy_res,
    input  logic [STEPS_W-1:0]         steps_left,
    input  logic signed [POS_W-1:0]    position,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [SPAN_W-1:0]          cfg_data,
    output int                         errors,
    output int                         pending
);

    typedef struct packed {
        logic               pin_a;
        logic               pin_b;
        logic               strobe;
        logic               busy;
        logic [STEPS_W-1:0] steps;
        logic [POS_W-1:0]   pos;
    } channel_out_t;

    // register copies
    logic              quad_sel;
    logic              abort_on_tick;
    logic [SPAN_W-1:0] span_ticks;

    // channel state
    logic              lvl_a;
    logic              lvl_b;
    logic              dir_neg;
    logic [15:0]       steps_to_go;
    logic [15:0]       period_ticks;
    logic [15:0]       interval_ticks;
    logic [POS_W-1:0]  pos_count;
    logic              moving;

    channel_out_t      due_outputs[$];

    task automatic report(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        errors++;
    endtask

    function automatic channel_out_t advance_channel(input logic is_move,
                                                     input logic [15:0] raw);
        logic [16:0]  mag;
        logic [31:0]  quot;
        logic [1:0]   ab;
        channel_out_t r;
        r.strobe = 1'b0;
        if (is_move)
        begin
            if (raw != 16'd0)
            begin
                mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
                if (mag > 17'hFFFF)
                    mag = 17'hFFFF;
                quot = span_ticks / {15'd0, mag};
                if (quot > 32'hFFFF)
                    quot = 32'hFFFF;
                dir_neg        = raw[15];
                steps_to_go    = mag[15:0];
                period_ticks   = quot[15:0];
                interval_ticks = 16'd0;
                moving         = 1'b1;
            end
        end
        else if (abort_on_tick)
        begin
            steps_to_go    = 16'd0;
            interval_ticks = 16'd0;
            moving         = 1'b0;
        end
        else if (moving)
        begin
            if (interval_ticks >= period_ticks)
            begin
                interval_ticks = 16'd0;
                r.strobe = 1'b1;
                if (quad_sel)
                begin
                    ab = {lvl_a, lvl_b};
                    if (!dir_neg)
                    begin
                        case (ab)
                            2'b00:   ab = 2'b10;
                            2'b10:   ab = 2'b11;
                            2'b11:   ab = 2'b01;
                            default: ab = 2'b00;
                        endcase
                    end
                    else
                    begin
                        case (ab)
                            2'b00:   ab = 2'b01;
                            2'b01:   ab = 2'b11;
                            2'b11:   ab = 2'b10;
                            default: ab = 2'b00;
                        endcase
                    end
                    lvl_a = ab[1];
                    lvl_b = ab[0];
                end
                else
                begin
                    lvl_a = 1'b1;
                    lvl_b = dir_neg;
                end
                pos_count   = dir_neg ? pos_count - 1 : pos_count + 1;
                steps_to_go = steps_to_go - 16'd1;
                if (steps_to_go == 16'd0)
                    moving = 1'b0;
            end
            else
            begin
                interval_ticks = interval_ticks + 16'd1;
            end
        end
        r.pin_a = quad_sel ? lvl_a : 1'b1;
        r.pin_b = lvl_b;
        r.busy  = moving;
        r.steps = steps_to_go;
        r.pos   = pos_count;
        return r;
    endfunction

    always @(posedge clk)
    begin
        channel_out_t want;
        if (!rst_n)
        begin
            quad_sel       = 1'b0;
            abort_on_tick  = 1'b0;
            span_ticks     = 32'd1000000;
            lvl_a          = 1'b0;
            lvl_b          = 1'b0;
            dir_neg        = 1'b0;
            steps_to_go    = 16'd0;
            period_ticks   = 16'd0;
            interval_ticks = 16'd0;
            pos_count      = '0;
            moving         = 1'b0;
            due_outputs.delete();
            errors         = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_QUAD_MODE:     quad_sel = cfg_data[0];
                    REG_COUNT_DISABLE: abort_on_tick = cfg_data[0];
                    REG_MOVE_SPAN:     span_ticks = cfg_data;
                    default:           ;
                endcase
            end
            // a result never belongs to an item accepted on the same edge
            if (out_valid && out_ready)
            begin
                if (due_outputs.size() == 0)
                begin
                    report("result with no item outstanding");
                end
                else
                begin
                    want = due_outputs.pop_front();
                    if (pin_a !== want.pin_a)
                        report($sformatf("pin_a %0b, want %0b", pin_a, want.pin_a));
                    if (pin_b !== want.pin_b)
                        report($sformatf("pin_b %0b, want %0b", pin_b, want.pin_b));
                    if (step_strobe !== want.strobe)
                        report($sformatf("step_strobe %0b, want %0b",
                                         step_strobe, want.strobe));
                    if (busy_res !== want.busy)
                        report($sformatf("busy_res %0b, want %0b", busy_res, want.busy));
                    if (steps_left !== want.steps)
                        report($sformatf("steps_left %0d, want %0d",
                                         steps_left, want.steps));
                    if (position !== want.pos)
                        report($sformatf("position %0d, want %0d",
                                         position, $signed(want.pos)));
                end
            end
            if (in_valid && in_ready)
                due_outputs.push_back(advance_channel(cmd, move_count));
        end
        pending = due_outputs.size();
    end

endmodule

/* bench/tb_quadrature_step_pulse_generator.sv */
module tb_quadrature_step_pulse_generator;
    import qspg_pkg::*;

    localparam int STALL_LIMIT = 4000;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic                       cmd;
    logic signed [MOVE_W-1:0]   move_count;
    logic                       out_valid;
    logic                       out_ready;
    logic                       pin_a;
    logic                       pin_b;
    logic                       step_strobe;
    logic                       busy_res;
    logic [STEPS_W-1:0]         steps_left;
    logic signed [POS_W-1:0]    position;
    logic                       cfg_we;
    logic [1:0]                 cfg_index;
    logic [SPAN_W-1:0]          cfg_data;

    int errors;
    int pending;
    int gap_max   = 13;
    int ready_max = 13;
    int stall_cycles = 0;

    quadrature_step_pulse_generator i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .move_count  (move_count),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pin_a       (pin_a),
        .pin_b       (pin_b),
        .step_strobe (step_strobe),
        .busy_res    (busy_res),
        .steps_left  (steps_left),
        .position    (position),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    qspg_channel_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .move_count  (move_count),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pin_a       (pin_a),
        .pin_b       (pin_b),
        .step_strobe (step_strobe),
        .busy_res    (busy_res),
        .steps_left  (steps_left),
        .position    (position),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .pending     (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_quadrature_step_pulse_generator: FAIL");
            $finish;
        end
    end

    // result side: hold off a random number of cycles before each result
    initial
    begin
        int hold;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            hold = $urandom_range(ready_max, 0);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    task automatic send_item(input logic is_move, input logic signed [MOVE_W-1:0] n);
        int gap;
        gap = $urandom_range(gap_max, 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= is_move;
        move_count <= n;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // drop valid and hold until every outstanding result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input qspg_reg_idx_t idx, input logic [SPAN_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic set_config(input logic quad, input logic dis, input logic [SPAN_W-1:0] span);
        wait_drained();
        write_reg(REG_QUAD_MODE, {31'd0, quad});
        write_reg(REG_COUNT_DISABLE, {31'd0, dis});
        write_reg(REG_MOVE_SPAN, span);
        cfg_we <= 1'b0;
    endtask

    task automatic random_item();
        int                      pick;
        int                      mag;
        logic signed [MOVE_W-1:0] n;
        pick = $urandom_range(99, 0);
        if (pick < 80)
        begin
            send_item(1'b0, MOVE_W'($urandom()));
        end
        else if (pick < 92)
        begin
            mag = $urandom_range(12, 1);
            n = MOVE_W'(mag);
            if ($urandom_range(1, 0) == 1)
                n = -n;
            send_item(1'b1, n);
        end
        else if (pick < 97)
        begin
            send_item(1'b1, MOVE_W'($urandom()));
        end
        else
        begin
            case ($urandom_range(4, 0))
                0:       n = 16'sh0000;
                1:       n = 16'sh0001;
                2:       n = -16'sh0001;
                3:       n = 16'sh7FFF;
                default: n = 16'sh8000;
            endcase
            send_item(1'b1, n);
        end
    endtask

    task automatic run_phase(input logic quad, input logic dis, input logic [SPAN_W-1:0] span,
                             input int n_items, input int gmax, input int rmax);
        set_config(quad, dis, span);
        gap_max   = gmax;
        ready_max = rmax;
        repeat (n_items)
        begin
            if ($urandom_range(59, 0) == 0)
                wait_drained();
            random_item();
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        cmd        = 1'b0;
        move_count = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: idle tick, zero move, count extremes, move replacing a move
        set_config(1'b0, 1'b0, 32'd3);
        send_item(1'b0, 16'sh0000);
        send_item(1'b1, 16'sh0000);
        send_item(1'b1, 16'sh0001);
        repeat (4) send_item(1'b0, 16'sh0000);
        send_item(1'b1, 16'sh8000);
        repeat (2) send_item(1'b0, 16'sh7FFF);
        send_item(1'b1, 16'sh7FFF);
        send_item(1'b0, 16'shFFFF);
        send_item(1'b1, -16'sh0001);
        repeat (4) send_item(1'b0, 16'sh0000);
        send_item(1'b0, 16'sh0000);
        wait_drained();

        run_phase(1'b1, 1'b0, 32'd40, 180, 13, 13);
        run_phase(1'b0, 1'b0, SPAN_W'($urandom_range(300, 1)), 150, 13, 0);
        run_phase(1'b1, 1'b1, 32'd20, 80, 13, 13);
        run_phase(1'b1, 1'b0, 32'hFFFF_FFFF, 60, 0, 13);
        run_phase(1'b0, 1'b0, 32'd1, 150, 0, 0);
        run_phase(1'b1, 1'b0, SPAN_W'($urandom_range(200, 1)), 200, 13, 13);
        run_phase(1'b0, 1'b1, 32'd1000000, 60, 13, 13);
        run_phase(1'b1, 1'b0, 32'd8, 180, 13, 13);

        wait_drained();
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("tb_quadrature_step_pulse_generator: PASS");
        else
            $display("tb_quadrature_step_pulse_generator: FAIL");
        $finish;
    end

endmodule
